[rtl/pds_pkg.sv]
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants for the priority decay scheduler.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int MAX_ENTRIES_DEF = 4;

  localparam int KIND_W  = 1;
  localparam int IDXF_W  = 4;
  localparam int DATA_W  = 8;
  localparam int BASE_W  = 7;
  localparam int ACT_W   = 5;
  localparam int CFGI_W  = 2;

  localparam logic [CFGI_W-1:0] CFG_BASE_PRIO = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_TICKS     = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_ACTIVE    = 2'd2;

  localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
  localparam logic [KIND_W-1:0] KIND_QUANTUM = 1'b1;

  localparam logic [BASE_W-1:0] BASE_PRIO_RST = 7'd60;
  localparam logic [DATA_W-1:0] TICKS_RST     = 8'd61;
  localparam logic [ACT_W-1:0]  ACTIVE_RST    = 5'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHARGE,
    ST_EMIT
  } pds_state_t;

  typedef struct packed {
    logic load;    // write one table entry from the input beat
    logic start;   // latch entry count, clear counter
    logic scan;    // compare one entry against running minimum
    logic charge;  // add ticks to chosen entry's usage
    logic emit;    // decay one entry and load the output register
  } pds_cmd_t;

  typedef struct packed {
    logic n_zero;    // no active entries
    logic cnt_last;  // counter sits on the last active entry
    logic out_free;  // output register can take a beat this cycle
  } pds_sts_t;

endpackage

[rtl/pds_ctrl.sv]
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer for load, scan, charge and decay/report phases.
// ----------------------------------------------------------------------------
module pds_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [pds_pkg::KIND_W-1:0]    in_kind,
  output logic                          in_ready,
  input  pds_pkg::pds_sts_t             sts,
  output pds_pkg::pds_cmd_t             cmd
);

  pds_pkg::pds_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pds_pkg::ST_IDLE: begin
        if (in_valid && in_kind == pds_pkg::KIND_QUANTUM && !sts.n_zero) begin
          state_nxt = pds_pkg::ST_SCAN;
        end
      end
      pds_pkg::ST_SCAN: begin
        if (sts.cnt_last) begin
          state_nxt = pds_pkg::ST_CHARGE;
        end
      end
      pds_pkg::ST_CHARGE: begin
        state_nxt = pds_pkg::ST_EMIT;
      end
      pds_pkg::ST_EMIT: begin
        if (sts.out_free && sts.cnt_last) begin
          state_nxt = pds_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      pds_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == pds_pkg::KIND_LOAD) begin
            cmd.load = 1'b1;
          end else if (!sts.n_zero) begin
            cmd.start = 1'b1;
          end
        end
      end
      pds_pkg::ST_SCAN:   cmd.scan   = 1'b1;
      pds_pkg::ST_CHARGE: cmd.charge = 1'b1;
      pds_pkg::ST_EMIT:   cmd.emit   = sts.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/pds_datapath.sv]
// ----------------------------------------------------------------------------
// pds_datapath
// Entry tables, config registers, min scan, charge, decay and output register.
// ----------------------------------------------------------------------------
module pds_datapath #(
  parameter int MAX_ENTRIES = pds_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pds_pkg::pds_cmd_t             cmd,
  output pds_pkg::pds_sts_t             sts,
  input  logic [pds_pkg::IDXF_W-1:0]    in_entry_index,
  input  logic [pds_pkg::DATA_W-1:0]    in_load_priority,
  input  logic [pds_pkg::DATA_W-1:0]    in_load_usage,
  input  logic                          cfg_valid,
  input  logic [pds_pkg::CFGI_W-1:0]    cfg_index,
  input  logic [pds_pkg::DATA_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pds_pkg::IDXF_W-1:0]    out_report_index,
  output logic [pds_pkg::DATA_W-1:0]    out_report_priority,
  output logic [pds_pkg::DATA_W-1:0]    out_report_usage,
  output logic                          out_was_chosen,
  output logic                          out_last
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int DW    = pds_pkg::DATA_W;
  localparam logic [pds_pkg::ACT_W-1:0] MAX_ACT = pds_pkg::ACT_W'(MAX_ENTRIES);

  logic [DW-1:0] prio_r  [MAX_ENTRIES];
  logic [DW-1:0] usage_r [MAX_ENTRIES];

  logic [pds_pkg::BASE_W-1:0] base_r;
  logic [DW-1:0]              ticks_r;
  logic [pds_pkg::ACT_W-1:0]  active_r;

  logic [CNT_W-1:0] n_r;
  logic [IDX_W-1:0] cnt_r;
  logic [IDX_W-1:0] best_r;
  logic [DW-1:0]    best_prio_r;
  logic [DW-1:0]    best_usage_r;
  logic [DW-1:0]    charged_r;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [DW-1:0]    out_prio_r;
  logic [DW-1:0]    out_usage_r;
  logic             out_chosen_r;
  logic             out_last_r;

  logic [CNT_W-1:0] n_eff;
  logic             load_in_range;
  logic [DW-1:0]    cur_prio;
  logic [DW-1:0]    cur_usage;
  logic             cur_chosen;
  logic [DW-1:0]    src_usage;
  logic [DW-1:0]    dec_usage;
  logic [DW-1:0]    dec_prio;
  logic [DW:0]      charge_sum;

  // entries beyond the table size do not take part
  assign n_eff = (active_r > MAX_ACT) ? CNT_W'(MAX_ACT) : CNT_W'(active_r);
  assign load_in_range = ({1'b0, in_entry_index} < MAX_ACT);

  assign cur_prio   = prio_r[cnt_r];
  assign cur_usage  = usage_r[cnt_r];
  assign cur_chosen = (cnt_r == best_r);

  // chosen entry takes its charged usage before decay
  assign src_usage  = cur_chosen ? charged_r : cur_usage;
  assign dec_usage  = {1'b0, src_usage[DW-1:1]};
  assign dec_prio   = {1'b0, base_r} + {2'b00, src_usage[DW-1:2]};
  assign charge_sum = {1'b0, best_usage_r} + {1'b0, ticks_r};

  assign sts.n_zero   = (active_r == '0);
  assign sts.cnt_last = ((CNT_W'(cnt_r) + CNT_W'(1)) == n_r);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= pds_pkg::BASE_PRIO_RST;
      ticks_r  <= pds_pkg::TICKS_RST;
      active_r <= pds_pkg::ACTIVE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pds_pkg::CFG_BASE_PRIO: base_r   <= cfg_data[pds_pkg::BASE_W-1:0];
        pds_pkg::CFG_TICKS:     ticks_r  <= cfg_data;
        pds_pkg::CFG_ACTIVE:    active_r <= cfg_data[pds_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        prio_r[i]  <= '0;
        usage_r[i] <= '0;
      end
    end else if (cmd.load && load_in_range) begin
      prio_r[in_entry_index[IDX_W-1:0]]  <= in_load_priority;
      usage_r[in_entry_index[IDX_W-1:0]] <= in_load_usage;
    end else if (cmd.emit) begin
      prio_r[cnt_r]  <= dec_prio;
      usage_r[cnt_r] <= dec_usage;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start || cmd.charge) begin
      cnt_r <= '0;
    end else if (cmd.scan || cmd.emit) begin
      cnt_r <= cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r <= n_eff;
    end
    // strict less-than keeps the lowest index on ties
    if (cmd.scan && (cnt_r == '0 || cur_prio < best_prio_r)) begin
      best_r       <= cnt_r;
      best_prio_r  <= cur_prio;
      best_usage_r <= cur_usage;
    end
    if (cmd.charge) begin
      charged_r <= charge_sum[DW] ? {DW{1'b1}} : charge_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r    <= cnt_r;
      out_prio_r   <= dec_prio;
      out_usage_r  <= dec_usage;
      out_chosen_r <= cur_chosen;
      out_last_r   <= sts.cnt_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_report_index    = pds_pkg::IDXF_W'(out_idx_r);
  assign out_report_priority = out_prio_r;
  assign out_report_usage    = out_usage_r;
  assign out_was_chosen      = out_chosen_r;
  assign out_last            = out_last_r;

endmodule

[rtl/priority_decay_scheduler_core.sv]
// ----------------------------------------------------------------------------
// priority_decay_scheduler_core
// Process table with lowest-priority selection, usage charge and decay.
// ----------------------------------------------------------------------------
// Input channel (in_*): a load beat (kind 0) writes one in-range entry and
// gives no output. A quantum beat (kind 1) scans the n active entries for the
// lowest priority (lowest index on ties), charges the chosen entry, then
// decays and reports every active entry in index order, one output beat each,
// the final one marked by out_last. n is active_entries capped at the table
// size; with n of zero a quantum gives no output.
// A quantum runs a min scan over the n entries through the single table read
// port, then a charge step, then a decay step for each entry, one per report.
// in_ready is high only while no quantum is in work.
// The output register holds a beat until out_ready; a stalled receiver stalls
// the decay phase, and the next input is taken while the last report waits.
// Config writes (cfg_*) are taken every cycle and should occur while idle.
// Reset clears the tables to zero and restores the register reset values.
// ----------------------------------------------------------------------------
module priority_decay_scheduler_core #(
  parameter int MAX_ENTRIES = pds_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pds_pkg::KIND_W-1:0]    in_kind,
  input  logic [pds_pkg::IDXF_W-1:0]    in_entry_index,
  input  logic [pds_pkg::DATA_W-1:0]    in_load_priority,
  input  logic [pds_pkg::DATA_W-1:0]    in_load_usage,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pds_pkg::CFGI_W-1:0]    cfg_index,
  input  logic [pds_pkg::DATA_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pds_pkg::IDXF_W-1:0]    out_report_index,
  output logic [pds_pkg::DATA_W-1:0]    out_report_priority,
  output logic [pds_pkg::DATA_W-1:0]    out_report_usage,
  output logic                          out_was_chosen,
  output logic                          out_last
);

  pds_pkg::pds_cmd_t cmd;
  pds_pkg::pds_sts_t sts;

  assign cfg_ready = 1'b1;

  pds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pds_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_entry_index      (in_entry_index),
    .in_load_priority    (in_load_priority),
    .in_load_usage       (in_load_usage),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_report_index    (out_report_index),
    .out_report_priority (out_report_priority),
    .out_report_usage    (out_report_usage),
    .out_was_chosen      (out_was_chosen),
    .out_last            (out_last)
  );

endmodule

[test/pds_report_checker.sv]
// ----------------------------------------------------------------------------
// pds_report_checker
// Watches the load/quantum, register and report channels of the scheduler,
// keeps its own copy of the process table and register set, queues the
// reports each quantum beat should give and compares every report beat
// field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module pds_report_checker
  import pds_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [IDXF_W-1:0] in_entry_index,
  input  logic [DATA_W-1:0] in_load_priority,
  input  logic [DATA_W-1:0] in_load_usage,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [IDXF_W-1:0] out_report_index,
  input  logic [DATA_W-1:0] out_report_priority,
  input  logic [DATA_W-1:0] out_report_usage,
  input  logic              out_was_chosen,
  input  logic              out_last,
  output int                pending,
  output int                errors
);

  localparam int IDX_W    = $clog2(MAX_ENTRIES);
  localparam int RQ_DEPTH = 8 * MAX_ENTRIES;

  typedef struct packed {
    logic [IDXF_W-1:0] idx;
    logic [DATA_W-1:0] prio;
    logic [DATA_W-1:0] usage;
    logic              chosen;
    logic              last_flag;
  } report_t;

  logic [DATA_W-1:0] prio_tbl  [MAX_ENTRIES];
  logic [DATA_W-1:0] usage_tbl [MAX_ENTRIES];
  logic [BASE_W-1:0] base_r;
  logic [DATA_W-1:0] ticks_r;
  logic [ACT_W-1:0]  act_r;

  // expected reports, oldest at rq_rd
  report_t rq_mem [RQ_DEPTH];
  int      rq_rd   = 0;
  int      rq_wr   = 0;
  int      rq_fill = 0;
  int      err_cnt = 0;

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t report %s mismatch: expected %0d actual %0d", $time, name, exp_v,
               act_v);
      err_cnt++;
    end
  endtask

  task automatic rq_put(input report_t r);
    if (rq_fill == RQ_DEPTH) begin
      $display("%0t expected report store overflow", $time);
      err_cnt++;
    end else begin
      rq_mem[rq_wr] = r;
      rq_wr         = (rq_wr + 1) % RQ_DEPTH;
      rq_fill++;
    end
  endtask

  // pick, charge, then decay and report the active entries
  task automatic schedule_quantum();
    int                n;
    int                best;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] u;
    logic [DATA_W-1:0] p;
    report_t           r;
    n = (act_r > MAX_ENTRIES) ? MAX_ENTRIES : int'(act_r);
    if (n == 0) return;
    best = 0;
    for (int i = 1; i < n; i++)
      if (prio_tbl[i] < prio_tbl[best]) best = i;
    sum = {1'b0, usage_tbl[best]} + {1'b0, ticks_r};
    usage_tbl[best] = sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
    for (int i = 0; i < n; i++) begin
      u = usage_tbl[i] >> 1;
      p = DATA_W'(base_r) + (u >> 1);
      usage_tbl[i] = u;
      prio_tbl[i]  = p;
      r.idx       = IDXF_W'(i);
      r.prio      = p;
      r.usage     = u;
      r.chosen    = (i == best);
      r.last_flag = (i == n - 1);
      rq_put(r);
    end
  endtask

  always @(posedge clk) begin
    report_t r;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        prio_tbl[i]  = '0;
        usage_tbl[i] = '0;
      end
      base_r  = BASE_PRIO_RST;
      ticks_r = TICKS_RST;
      act_r   = ACTIVE_RST;
      rq_rd   = 0;
      rq_wr   = 0;
      rq_fill = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_PRIO: base_r  = cfg_data[BASE_W-1:0];
          CFG_TICKS:     ticks_r = cfg_data;
          CFG_ACTIVE:    act_r   = cfg_data[ACT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (rq_fill == 0) begin
          $display("%0t unexpected report beat: index %0d priority %0d usage %0d",
                   $time, out_report_index, out_report_priority, out_report_usage);
          err_cnt++;
        end else begin
          r     = rq_mem[rq_rd];
          rq_rd = (rq_rd + 1) % RQ_DEPTH;
          rq_fill--;
          check_field("index", r.idx, out_report_index);
          check_field("priority", r.prio, out_report_priority);
          check_field("usage", r.usage, out_report_usage);
          check_field("was_chosen", r.chosen, out_was_chosen);
          check_field("last", r.last_flag, out_last);
        end
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_QUANTUM) begin
          schedule_quantum();
        end else if (in_entry_index < MAX_ENTRIES) begin
          prio_tbl[in_entry_index[IDX_W-1:0]]  = in_load_priority;
          usage_tbl[in_entry_index[IDX_W-1:0]] = in_load_usage;
        end
      end
    end
    pending <= rq_fill;
    errors  <= err_cnt;
  end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for priority_decay_scheduler_core. Drives directed
// loads and quanta over the register extremes, a back-pressure phase and
// random phases with bursty input and a stalling report receiver; the
// report checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import pds_pkg::*;

  localparam int                MAXE          = MAX_ENTRIES_DEF;
  localparam logic [CFGI_W-1:0] CFG_UNUSED    = 2'd3;
  localparam int                ITEM_TARGET   = 130;
  localparam int                DRAIN_LIMIT   = 20000;
  localparam int                SETTLE_CYCLES = 8;
  localparam int                LONG_HOLD     = 120;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] in_kind          = KIND_LOAD;
  logic [IDXF_W-1:0] in_entry_index   = '0;
  logic [DATA_W-1:0] in_load_priority = '0;
  logic [DATA_W-1:0] in_load_usage    = '0;
  logic              cfg_valid        = 1'b0;
  logic              cfg_ready;
  logic [CFGI_W-1:0] cfg_index        = CFG_BASE_PRIO;
  logic [DATA_W-1:0] cfg_data         = '0;
  logic              out_valid;
  logic              out_ready        = 1'b1;
  logic [IDXF_W-1:0] out_report_index;
  logic [DATA_W-1:0] out_report_priority;
  logic [DATA_W-1:0] out_report_usage;
  logic              out_was_chosen;
  logic              out_last;

  int   chk_pending;
  int   chk_errors;
  int   beats_sent    = 0;
  logic long_hold_arm = 1'b0;

  always #2 clk = ~clk;

  priority_decay_scheduler_core #(.MAX_ENTRIES(MAXE)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_entry_index      (in_entry_index),
    .in_load_priority    (in_load_priority),
    .in_load_usage       (in_load_usage),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_report_index    (out_report_index),
    .out_report_priority (out_report_priority),
    .out_report_usage    (out_report_usage),
    .out_was_chosen      (out_was_chosen),
    .out_last            (out_last)
  );

  pds_report_checker #(.MAX_ENTRIES(MAXE)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_entry_index      (in_entry_index),
    .in_load_priority    (in_load_priority),
    .in_load_usage       (in_load_usage),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_report_index    (out_report_index),
    .out_report_priority (out_report_priority),
    .out_report_usage    (out_report_usage),
    .out_was_chosen      (out_was_chosen),
    .out_last            (out_last),
    .pending             (chk_pending),
    .errors              (chk_errors)
  );

  // report receiver: one long hold when armed, otherwise a changing stall mode
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int rx_mode      = 0;
  int rx_mode_left = 0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (long_hold_arm && !hold_done) begin
      out_ready <= 1'b0;
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(8, 48);
      end else begin
        rx_mode_left = rx_mode_left - 1;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  // leaves valid high so a following beat can go out on the next edge
  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [IDXF_W-1:0] idx,
                           input logic [DATA_W-1:0] prio, input logic [DATA_W-1:0] usage);
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_entry_index   <= idx;
    in_load_priority <= prio;
    in_load_usage    <= usage;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == KIND_QUANTUM || idx < MAXE) beats_sent++;
  endtask

  task automatic load_entry(input logic [IDXF_W-1:0] idx, input logic [DATA_W-1:0] prio,
                            input logic [DATA_W-1:0] usage);
    send_beat(KIND_LOAD, idx, prio, usage);
  endtask

  // unused fields of a quantum beat carry noise
  task automatic run_quantum();
    send_beat(KIND_QUANTUM, IDXF_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic close_cfg();
    cfg_valid <= 1'b0;
  endtask

  // stop offering, wait out every queued report, then let the block settle
  task automatic wait_reports_done();
    int guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // extremes and a small tie-prone set show up often
  function automatic logic [DATA_W-1:0] rand_byte();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0:       return '0;
      1:       return '1;
      2, 3:    return DATA_W'($urandom_range(10, 12));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    int               phase_len;
    int               burst_left;
    int               pick;
    bit               no_gaps;
    logic [ACT_W-1:0] act;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-zero table ties to entry 0, then loads incl. inactive
    // and out-of-range entries
    run_quantum();
    load_entry(4'd0, 8'd255, 8'd255);
    load_entry(4'd1, 8'd0, 8'd0);
    load_entry(4'd2, 8'd128, 8'd200);
    load_entry(4'd3, 8'd0, 8'd77);
    load_entry(4'd15, 8'd0, 8'd0);
    load_entry(IDXF_W'(MAXE), 8'd12, 8'd34);
    run_quantum();
    run_quantum();
    wait_reports_done();

    // top extremes; active above table size, base written with bit 7 set
    write_reg(CFG_BASE_PRIO, 8'hFF);
    write_reg(CFG_TICKS, 8'd255);
    write_reg(CFG_ACTIVE, 8'd16);
    close_cfg();
    load_entry(4'd2, 8'd0, 8'd255);
    load_entry(4'd3, 8'd255, 8'd0);
    run_quantum();
    run_quantum();
    wait_reports_done();

    // no active entries: a quantum gives nothing
    write_reg(CFG_ACTIVE, 8'hE0);
    close_cfg();
    run_quantum();
    load_entry(4'd1, 8'd10, 8'd250);
    wait_reports_done();

    write_reg(CFG_ACTIVE, 8'd1);
    write_reg(CFG_TICKS, 8'd1);
    write_reg(CFG_BASE_PRIO, 8'd0);
    close_cfg();
    run_quantum();
    run_quantum();
    wait_reports_done();

    write_reg(CFG_ACTIVE, 8'h1F);
    write_reg(CFG_TICKS, 8'h80);
    write_reg(CFG_UNUSED, 8'h55);
    write_reg(CFG_BASE_PRIO, 8'h2A);
    close_cfg();
    run_quantum();
    load_entry(4'd0, 8'd0, 8'd0);
    run_quantum();
    wait_reports_done();

    // back pressure: receiver holds off while quanta keep coming
    write_reg(CFG_ACTIVE, DATA_W'(MAXE));
    write_reg(CFG_TICKS, DATA_W'($urandom_range(1, 255)));
    close_cfg();
    long_hold_arm <= 1'b1;
    repeat (8) run_quantum();
    wait_reports_done();

    // random phases, each with its own setting
    while (beats_sent < ITEM_TARGET) begin
      write_reg(CFG_BASE_PRIO, DATA_W'($urandom));
      pick = $urandom_range(0, 7);
      write_reg(CFG_TICKS, (pick == 0) ? 8'd1 : (pick == 1) ? 8'd255
                                       : DATA_W'($urandom_range(1, 255)));
      pick = $urandom_range(0, 9);
      if (pick == 0) act = '0;
      else if (pick < 3) act = ACT_W'($urandom_range(MAXE + 1, 31));
      else act = ACT_W'($urandom_range(1, MAXE));
      write_reg(CFG_ACTIVE, {3'($urandom_range(0, 7)), act});
      if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, DATA_W'($urandom));
      close_cfg();

      phase_len  = $urandom_range(10, 25);
      burst_left = 0;
      no_gaps    = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 10);
          if (!no_gaps) pause($urandom_range(1, 6));
        end
        burst_left--;
        pick = $urandom_range(0, 9);
        if (pick < 3) run_quantum();
        else if (pick < 9) load_entry(IDXF_W'($urandom_range(0, MAXE - 1)), rand_byte(),
                                      rand_byte());
        else load_entry(IDXF_W'($urandom), rand_byte(), rand_byte());
      end
      wait_reports_done();
    end

    if (chk_errors == 0 && chk_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("Verification failed");
    $finish;
  end

endmodule
